// ===== rtl/bba_pkg.sv =====
// Shared constants and types for the buddy block allocator.
package bba_pkg;
	localparam int NumOrders = 8;
	localparam int OrdW = $clog2(NumOrders + 1);
	localparam int AddrW = NumOrders - 1;
	localparam int IdxW = NumOrders;
	localparam int Words = 1 << NumOrders;

	localparam logic [1:0] StDone = 2'd0;
	localparam logic [1:0] StOversize = 2'd1;
	localparam logic [1:0] StNoFree = 2'd2;

	typedef struct packed {
		logic [AddrW-1:0] granted_address;
		logic [1:0] status;
	} result_t;

	function automatic logic [IdxW-1:0] mark_index(input logic [OrdW-1:0] ord,
			input logic [AddrW-1:0] addr);
		logic [IdxW-1:0] base;
		logic [IdxW-1:0] off;
		base = IdxW'(1) << (IdxW'(NumOrders - 1) - IdxW'(ord));
		off = IdxW'(addr >> ord) & (base - IdxW'(1));
		return base | off;
	endfunction
endpackage

// ===== rtl/buddy_block_allocator_unit.sv =====
// Buddy block allocator top level: free-mark memory and sequencer.
// channel | dir | fields
// s_axis  | in  | tdata: cmd, request_size, block_address
// m_axis  | out | tdata: granted_address, status
// An allocate sweeps the mark memory from the order's first index up to the top node,
// reading each mark in SRD and checking it in SCHK, then steps through SPLIT once per
// split level. A free reads the buddy's mark in FRD and checks it in FCHK for each
// merge level.
// After reset a clearing pass over all 2^NumOrders marks runs; no beat is taken then.
// Input is taken whenever the sequencer is idle; a result waiting in the output
// register holds the sequencer in its done state.
module buddy_block_allocator_unit (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [15:0] s_axis_tdata, // cmd, request_size, block_address
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [15:0] m_axis_tdata // granted_address, status, pad
);
	localparam int IW = bba_pkg::IdxW;
	localparam int AW = bba_pkg::AddrW;
	localparam int OW = bba_pkg::OrdW;

	typedef enum logic [2:0] {CLR, IDLE, SRD, SCHK, SPLIT, FRD, FCHK, DONE} st_t;
	st_t st_q;

	logic mem [bba_pkg::Words];
	logic rd_q;
	logic [IW-1:0] ra, wa;
	logic re, we, wd;

	logic [IW-1:0] idx_q;
	logic [OW-1:0] ord_q, k_q;
	logic [AW-1:0] addr_q;
	bba_pkg::result_t res_q;
	bba_pkg::result_t out_q;
	logic outv_q;

	logic cmd_in;
	logic [7:0] size_in;
	logic [AW-1:0] baddr_in;
	logic [OW-1:0] ord_in;
	assign cmd_in = s_axis_tdata[0];
	assign size_in = s_axis_tdata[8:1];
	assign baddr_in = s_axis_tdata[9 +: AW];

	logic [IW:0] idx_nx;
	assign idx_nx = {1'b0, idx_q} + (IW+1)'(1);

	always_comb begin
		ord_in = OW'(bba_pkg::NumOrders);
		for (int i = bba_pkg::NumOrders - 1; i >= 0; i--) begin
			if (9'(size_in) <= (9'(1) << i))
				ord_in = OW'(i);
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[wa] <= wd;
		if (re)
			rd_q <= mem[ra];
	end

	logic [AW-1:0] blk_addr;
	logic [OW-1:0] lvl;
	always_comb begin
		lvl = OW'(bba_pkg::NumOrders - 1);
		for (int i = 0; i < bba_pkg::NumOrders; i++) begin
			if (idx_q[i])
				lvl = OW'(bba_pkg::NumOrders - 1 - i);
		end
		blk_addr = AW'((idx_q & ~(IW'(1) << (IW'(bba_pkg::NumOrders - 1) - IW'(lvl)))) << lvl);
	end

	logic [AW-1:0] bud_addr;
	assign bud_addr = addr_q ^ (AW'(1) << k_q);

	always_comb begin
		re = 1'b0;
		ra = idx_q;
		we = 1'b0;
		wa = idx_q;
		wd = 1'b0;
		case (st_q)
			CLR: begin
				we = 1'b1;
				wd = (idx_q == IW'(1));
			end
			SRD: re = 1'b1;
			SCHK: if (rd_q) we = 1'b1;
			SPLIT: if (k_q > ord_q) begin
				we = 1'b1;
				wd = 1'b1;
				wa = bba_pkg::mark_index(k_q - OW'(1), addr_q ^ (AW'(1) << (k_q - OW'(1))));
			end
			FRD: if (k_q < OW'(bba_pkg::NumOrders - 1)) begin
				re = 1'b1;
				ra = bba_pkg::mark_index(k_q, bud_addr);
			end else begin
				we = 1'b1;
				wd = 1'b1;
				wa = bba_pkg::mark_index(k_q, addr_q);
			end
			FCHK: begin
				we = 1'b1;
				if (rd_q)
					wa = bba_pkg::mark_index(k_q, bud_addr);
				else begin
					wd = 1'b1;
					wa = bba_pkg::mark_index(k_q, addr_q);
				end
			end
			default: ;
		endcase
	end

	assign s_axis_tready = (st_q == IDLE);
	assign m_axis_tvalid = outv_q;
	assign m_axis_tdata = {7'd0, out_q.status, out_q.granted_address};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= CLR;
			idx_q <= '0;
			outv_q <= 1'b0;
			ord_q <= '0;
			k_q <= '0;
			addr_q <= '0;
			res_q <= '0;
			out_q <= '0;
		end else begin
			if (st_q == DONE && (!outv_q || m_axis_tready))
				outv_q <= 1'b1;
			else if (m_axis_tready)
				outv_q <= 1'b0;
			case (st_q)
				CLR: begin
					idx_q <= idx_q + IW'(1);
					if (idx_q == IW'(bba_pkg::Words - 1))
						st_q <= IDLE;
				end
				IDLE: if (s_axis_tvalid && s_axis_tready) begin
					ord_q <= ord_in;
					k_q <= ord_in;
					addr_q <= baddr_in & ~((AW'(1) << ord_in) - AW'(1));
					if (ord_in >= OW'(bba_pkg::NumOrders)) begin
						res_q <= '{granted_address: '0, status: bba_pkg::StOversize};
						st_q <= DONE;
					end else begin
						res_q <= '{granted_address: '0, status: bba_pkg::StDone};
						if (!cmd_in) begin
							idx_q <= IW'(1) << (IW'(bba_pkg::NumOrders - 1) - IW'(ord_in));
							st_q <= SRD;
						end else
							st_q <= FRD;
					end
				end
				SRD: st_q <= SCHK;
				SCHK: if (rd_q) begin
					addr_q <= blk_addr;
					k_q <= lvl;
					st_q <= SPLIT;
				end else if (idx_q == IW'(1)) begin
					res_q.status <= bba_pkg::StNoFree;
					st_q <= DONE;
				end else begin
					// past the last node of an order: go to the first node of the next one up
					idx_q <= ((idx_nx[IW-1:0] & idx_q) == IW'(0)) ? IW'(idx_nx >> 2) :
						idx_nx[IW-1:0];
					st_q <= SRD;
				end
				SPLIT: if (k_q > ord_q)
					k_q <= k_q - OW'(1);
				else begin
					res_q.granted_address <= addr_q;
					st_q <= DONE;
				end
				FRD: if (k_q < OW'(bba_pkg::NumOrders - 1))
					st_q <= FCHK;
				else
					st_q <= DONE;
				FCHK: if (rd_q) begin
					addr_q <= addr_q & ~(AW'(1) << k_q);
					k_q <= k_q + OW'(1);
					st_q <= FRD;
				end else
					st_q <= DONE;
				DONE: if (!outv_q || m_axis_tready) begin
					out_q <= res_q;
					st_q <= IDLE;
				end
				default: st_q <= IDLE;
			endcase
		end
	end

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> st_q != IDLE) else $error("beat not started");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");
	a_done_valid: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == DONE |=> m_axis_tvalid) else $error("result lost");
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> out_q.status != 2'd3) else $error("bad status");
endmodule
